// ----- src/plm_pkg.sv -----
// Shared types, widths and limits for the permutation statistics block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

   // Longest permutation that is counted; longer runs freeze the state.
   localparam int MAX_LEN   = 64;

   localparam int VALUE_W   = 7;
   localparam int DIGIT_W   = 6;
   localparam int SUM_W     = 11;
   localparam int BITMAP_W  = MAX_LEN;
   localparam int IDX_W     = $clog2(BITMAP_W);
   localparam int COUNT_W   = $clog2(MAX_LEN + 1);
   localparam int PROD_W    = DIGIT_W + COUNT_W;
   localparam int CO_W      = (PROD_W > SUM_W) ? PROD_W : SUM_W;

   localparam int DIGIT_MAX = (1 << DIGIT_W) - 1;
   localparam int SUM_MAX   = (1 << SUM_W) - 1;

   typedef struct packed {
      logic [VALUE_W-1:0] element_value;
      logic               is_last;
   } req_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] lehmer_digit;
      logic [SUM_W-1:0]   inversions;
      logic [SUM_W-1:0]   major_index;
      logic [SUM_W-1:0]   comajor_index;
      logic               is_permutation;
      logic               final_result;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/permutation_lehmer_statistics.sv -----
// Permutation statistics: Lehmer digit per entry, and inversions, major and
// comajor index and a permutation check on the last entry of each run.
// Each accepted word's result is in the output register in the next cycle; one word
// per cycle enters unless the output stalls; bitmap count and sums take one pass.
// Reset (synchronous, active high) clears the state and empties the output register;
// the state also clears itself after every last entry.
`timescale 1ns / 1ps
`default_nettype none

module permutation_lehmer_statistics (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire plm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output plm_pkg::rsp_type      rsp_data
);
   import plm_pkg::*;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff;
   logic                advance;
   logic [BITMAP_W-1:0] seen;
   logic [COUNT_W-1:0]  rank;
   rsp_type             result;

   // A new word may enter whenever the output register is empty or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid && req_ready;

   plm_rank u_rank (
      .seen          (seen),
      .element_value (req_data.element_value),
      .rank          (rank)
   );

   plm_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req_data (req_data),
      .rank     (rank),
      .seen     (seen),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- src/plm_rank.sv -----
// Masked population count of the seen-values bitmap: how many seen values
// lie above the incoming entry. Depends on plm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plm_rank (
   input  wire logic [plm_pkg::BITMAP_W-1:0] seen,
   input  wire logic [plm_pkg::VALUE_W-1:0]  element_value,
   output logic      [plm_pkg::COUNT_W-1:0]  rank
);
   import plm_pkg::*;

   localparam int NGROUP = (BITMAP_W + 7) / 8;
   localparam int PAD_W  = NGROUP * 8;

   logic [BITMAP_W-1:0] above;
   logic [PAD_W-1:0]    padded;
   logic [3:0]          group_count [NGROUP];

   // Bit i stands for value i+1, so bits at index >= v hold values above v.
   always_comb begin
      for (int i = 0; i < BITMAP_W; i++) begin
         above[i] = seen[i] & (VALUE_W'(i) >= element_value);
      end
      padded = PAD_W'(above);
   end

   // Two-level count: eight bits per group, then the group totals.
   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         group_count[g] = '0;
         for (int b = 0; b < 8; b++) begin
            group_count[g] = group_count[g] + 4'(padded[g*8 + b]);
         end
      end
      rank = '0;
      for (int g = 0; g < NGROUP; g++) begin
         rank = rank + COUNT_W'(group_count[g]);
      end
   end

endmodule

`default_nettype wire

// ----- src/plm_accum.sv -----
// Running state of the permutation (bitmap, counters, sums) and the result
// word built from it for the entry being taken. Depends on plm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plm_accum (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire plm_pkg::req_type            req_data,
   input  wire logic [plm_pkg::COUNT_W-1:0] rank,
   output logic [plm_pkg::BITMAP_W-1:0]     seen,
   output plm_pkg::rsp_type                 result
);
   import plm_pkg::*;

   logic [BITMAP_W-1:0] seen_ff,     seen_in;
   logic [VALUE_W-1:0]  previous_ff, previous_in;
   logic [COUNT_W-1:0]  count_ff,    count_in;
   logic [SUM_W-1:0]    inv_ff,      inv_in;
   logic [SUM_W-1:0]    major_ff,    major_in;
   logic [DIGIT_W-1:0]  descent_ff,  descent_in;
   logic [VALUE_W-1:0]  largest_ff,  largest_in;
   logic                invalid_ff,  invalid_in;

   logic [VALUE_W-1:0]  v;
   logic [VALUE_W-1:0]  bit_pos;
   logic                in_range;
   logic [SUM_W:0]      inv_sum;
   logic [SUM_W:0]      major_sum;
   logic [PROD_W-1:0]   product;
   logic [CO_W-1:0]     co_raw;

   assign v        = req_data.element_value;
   assign in_range = (v != '0) && ({1'b0, v} <= (VALUE_W+1)'(MAX_LEN));
   assign bit_pos  = v - VALUE_W'(1);
   assign seen     = seen_ff;

   always_comb begin
      seen_in     = seen_ff;
      previous_in = previous_ff;
      count_in    = count_ff;
      inv_in      = inv_ff;
      major_in    = major_ff;
      descent_in  = descent_ff;
      largest_in  = largest_ff;
      invalid_in  = invalid_ff;
      inv_sum     = {1'b0, inv_ff} + (SUM_W+1)'(rank);
      major_sum   = {1'b0, major_ff} + (SUM_W+1)'(count_ff);

      // Past the length limit the state freezes; only the flag moves.
      if ({1'b0, count_ff} >= (COUNT_W+1)'(MAX_LEN)) begin
         invalid_in = 1'b1;
      end else begin
         if (in_range) begin
            if (seen_ff[bit_pos[IDX_W-1:0]]) begin
               invalid_in = 1'b1;
            end
            seen_in[bit_pos[IDX_W-1:0]] = 1'b1;
         end else begin
            invalid_in = 1'b1;
         end
         inv_in = (inv_sum > (SUM_W+1)'(SUM_MAX)) ? SUM_W'(SUM_MAX) : inv_sum[SUM_W-1:0];
         if ((count_ff != '0) && (previous_ff > v)) begin
            major_in = (major_sum > (SUM_W+1)'(SUM_MAX)) ?
                       SUM_W'(SUM_MAX) : major_sum[SUM_W-1:0];
            if (descent_ff != DIGIT_W'(DIGIT_MAX)) begin
               descent_in = descent_ff + DIGIT_W'(1);
            end
         end
         if (v > largest_ff) begin
            largest_in = v;
         end
         previous_in = v;
         count_in    = count_ff + COUNT_W'(1);
      end
   end

   // The comajor index uses the counts that include this entry.
   assign product = PROD_W'(descent_in) * PROD_W'(count_in);
   assign co_raw  = (CO_W'(product) >= CO_W'(major_in)) ?
                    CO_W'(product) - CO_W'(major_in) : '0;

   always_comb begin
      result.lehmer_digit   = ((COUNT_W+1)'(rank) > (COUNT_W+1)'(DIGIT_MAX)) ?
                              DIGIT_W'(DIGIT_MAX) : DIGIT_W'(rank);
      result.final_result   = req_data.is_last;
      result.inversions     = '0;
      result.major_index    = '0;
      result.comajor_index  = '0;
      result.is_permutation = 1'b0;
      if (req_data.is_last) begin
         result.inversions     = inv_in;
         result.major_index    = major_in;
         result.comajor_index  = (co_raw > CO_W'(SUM_MAX)) ?
                                 SUM_W'(SUM_MAX) : co_raw[SUM_W-1:0];
         result.is_permutation = !invalid_in &&
                                 ((COUNT_W+VALUE_W)'(largest_in) ==
                                  (COUNT_W+VALUE_W)'(count_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && req_data.is_last)) begin
         seen_ff     <= '0;
         previous_ff <= '0;
         count_ff    <= '0;
         inv_ff      <= '0;
         major_ff    <= '0;
         descent_ff  <= '0;
         largest_ff  <= '0;
         invalid_ff  <= 1'b0;
      end else if (advance) begin
         seen_ff     <= seen_in;
         previous_ff <= previous_in;
         count_ff    <= count_in;
         inv_ff      <= inv_in;
         major_ff    <= major_in;
         descent_ff  <= descent_in;
         largest_ff  <= largest_in;
         invalid_ff  <= invalid_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/plm_checker.sv -----
// Port-level checks for permutation_lehmer_statistics, bound to the top level.
// Depends on plm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire plm_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire plm_pkg::rsp_type rsp_data
);
   import plm_pkg::*;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // A waiting result word holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Every accepted word shows its result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid && (rsp_data.final_result == $past(req_data.is_last)))
      else $error("result missing or last mark wrong");

   // Totals appear only on the final result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.final_result |->
         (rsp_data.inversions == '0) && (rsp_data.major_index == '0) &&
         (rsp_data.comajor_index == '0) && !rsp_data.is_permutation)
      else $error("totals on a result that is not final");

   // The first entry after a last entry sees an empty bitmap.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.is_last) ##1 req_fire |=> rsp_data.lehmer_digit == '0)
      else $error("state not cleared after last entry");

endmodule

bind permutation_lehmer_statistics plm_checker u_plm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the permutation statistics block: runs of entries go in,
// Lehmer digits and the per-run totals come back and are checked word by word.
// Depends on plm_pkg and permutation_lehmer_statistics from the source folder.
`timescale 1ns / 1ps

module tb_top;
   import plm_pkg::*;

   localparam int ITEM_TARGET = 1350;

   typedef enum int {
      RUN_PERM,
      RUN_MONOTONE,
      RUN_DUPLICATE,
      RUN_OUT_OF_RANGE,
      RUN_OVERLONG,
      RUN_NOISE
   } run_kind_type;

   // Tracks the statistics of the current run and queues the expected result words.
   class lehmer_scoreboard_type;
      logic [MAX_LEN-1:0] seen_map;
      logic [VALUE_W-1:0] last_value;
      logic [VALUE_W-1:0] entry_total;
      logic [SUM_W-1:0]   inversion_total;
      logic [SUM_W-1:0]   major_total;
      logic [DIGIT_W-1:0] descent_total;
      logic [VALUE_W-1:0] peak_value;
      bit                 broken_run;
      rsp_type            expected_q[$];
      int                 errors;
      int                 results_checked;
      int                 perms_confirmed;

      function new();
         errors = 0;
         results_checked = 0;
         perms_confirmed = 0;
         clear();
      endfunction

      function void clear();
         seen_map = '0;
         last_value = '0;
         entry_total = '0;
         inversion_total = '0;
         major_total = '0;
         descent_total = '0;
         peak_value = '0;
         broken_run = 1'b0;
      endfunction

      function int clip(int value, int top);
         return (value > top) ? top : value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_word(req_type w);
         int      v;
         int      digit;
         int      co;
         rsp_type want;
         v = w.element_value;
         // Values above v sit at bitmap indices v and upwards; a zero counts everything.
         digit = $countones(seen_map >> v);
         if (entry_total >= MAX_LEN) begin
            // Overlong run: the state is frozen but the digit still comes from the bitmap.
            broken_run = 1'b1;
         end else begin
            if (v >= 1 && v <= MAX_LEN) begin
               if (seen_map[v-1]) begin
                  broken_run = 1'b1;
               end
               seen_map[v-1] = 1'b1;
            end else begin
               broken_run = 1'b1;
            end
            inversion_total = SUM_W'(clip(int'(inversion_total) + digit, SUM_MAX));
            if (entry_total >= 1 && last_value > v) begin
               major_total = SUM_W'(clip(int'(major_total) + int'(entry_total), SUM_MAX));
               descent_total = DIGIT_W'(clip(int'(descent_total) + 1, DIGIT_MAX));
            end
            if (v > peak_value) begin
               peak_value = VALUE_W'(v);
            end
            last_value = VALUE_W'(v);
            entry_total = entry_total + 1'b1;
         end
         want = '0;
         want.lehmer_digit = DIGIT_W'(clip(digit, DIGIT_MAX));
         if (w.is_last) begin
            co = int'(descent_total) * int'(entry_total);
            co = (co >= int'(major_total)) ? co - int'(major_total) : 0;
            want.inversions = inversion_total;
            want.major_index = major_total;
            want.comajor_index = SUM_W'(clip(co, SUM_MAX));
            want.is_permutation = !broken_run && (peak_value == entry_total);
            want.final_result = 1'b1;
            clear();
         end
         expected_q.insert(expected_q.size(), want);
      endfunction

      task report(string msg);
         if (errors < 200) begin
            $display("MISMATCH: %s", msg);
         end
         errors++;
      endtask

      task check_word(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result word %0d arrived with nothing expected", results_checked));
         end else begin
            want = expected_q.pop_front();
            if (got.lehmer_digit !== want.lehmer_digit)
               report($sformatf("word %0d lehmer_digit %0d, expected %0d",
                                results_checked, got.lehmer_digit, want.lehmer_digit));
            if (got.inversions !== want.inversions)
               report($sformatf("word %0d inversions %0d, expected %0d",
                                results_checked, got.inversions, want.inversions));
            if (got.major_index !== want.major_index)
               report($sformatf("word %0d major_index %0d, expected %0d",
                                results_checked, got.major_index, want.major_index));
            if (got.comajor_index !== want.comajor_index)
               report($sformatf("word %0d comajor_index %0d, expected %0d",
                                results_checked, got.comajor_index, want.comajor_index));
            if (got.is_permutation !== want.is_permutation)
               report($sformatf("word %0d is_permutation %0d, expected %0d",
                                results_checked, got.is_permutation, want.is_permutation));
            if (got.final_result !== want.final_result)
               report($sformatf("word %0d final_result %0d, expected %0d",
                                results_checked, got.final_result, want.final_result));
            if (want.final_result && want.is_permutation) begin
               perms_confirmed++;
            end
         end
         results_checked++;
      endtask
   endclass

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   lehmer_scoreboard_type sb = new();
   int  run_vals[$];
   int  words_sent = 0;
   int  runs_played = 0;
   int  overlong_runs = 0;
   bit  steady = 1'b0;

   permutation_lehmer_statistics dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Sends the entries in run_vals as one run, marking the final word as last.
   task automatic play_run();
      req_type w;
      int      gap;
      for (int i = 0; i < run_vals.size(); i++) begin
         w.element_value = VALUE_W'(run_vals[i]);
         w.is_last = (i == run_vals.size() - 1);
         gap = steady ? 0 : $urandom_range(9, 0);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data <= w;
         do @(posedge clock); while (!req_ready);
         sb.note_word(w);
         words_sent++;
      end
      runs_played++;
   endtask

   // Holds the sender off until every outstanding result word has been checked.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic build_run(input run_kind_type kind, input int len);
      int tmp;
      int j;
      int k;
      run_vals.delete();
      if (kind == RUN_NOISE) begin
         for (int i = 0; i < len; i++) begin
            run_vals.insert(run_vals.size(), int'($urandom_range(127, 0)));
         end
      end else begin
         for (int i = 1; i <= len; i++) run_vals.insert(run_vals.size(), i);
         if (kind == RUN_MONOTONE) begin
            if ($urandom_range(1, 0) == 1) run_vals.reverse();
         end else begin
            for (int i = len - 1; i > 0; i--) begin
               j = $urandom_range(i, 0);
               tmp = run_vals[i];
               run_vals[i] = run_vals[j];
               run_vals[j] = tmp;
            end
         end
      end
      case (kind)
         RUN_DUPLICATE: begin
            j = $urandom_range(len - 1, 0);
            k = $urandom_range(len - 1, 0);
            if (k == j) k = (j + 1) % len;
            run_vals[j] = run_vals[k];
         end
         RUN_OUT_OF_RANGE: begin
            j = $urandom_range(len - 1, 0);
            run_vals[j] = ($urandom_range(1, 0) == 1) ? 0 : $urandom_range(127, MAX_LEN + 1);
         end
         RUN_OVERLONG: begin
            k = $urandom_range(4, 1);
            for (int i = 0; i < k; i++) begin
               run_vals.insert(run_vals.size(),
                               ($urandom_range(2, 0) == 0) ? 0 : int'($urandom_range(127, 0)));
            end
         end
         default: ;
      endcase
   endtask

   function automatic int pick_len();
      int r;
      r = $urandom_range(99, 0);
      if (r < 80) return $urandom_range(10, 1);
      if (r < 95) return $urandom_range(MAX_LEN - 1, 11);
      return MAX_LEN;
   endfunction

   initial begin
      int           r;
      int           len;
      run_kind_type kind;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed runs: single entry, a descent, sorted, both value extremes,
      // a duplicate, the top legal value next to the first illegal one, a gap
      // in the values, and a zero after other entries.
      run_vals = '{1};          play_run();
      run_vals = '{2, 1};       play_run();
      run_vals = '{1, 2, 3};    play_run();
      run_vals = '{0, 127};     play_run();
      run_vals = '{2, 2, 1};    play_run();
      run_vals = '{64, 65, 1};  play_run();
      run_vals = '{1, 3};       play_run();
      run_vals = '{3, 1, 2, 0}; play_run();
      drain();

      // Full-length runs: reversed gives every sum at its largest, and an
      // overlong run whose first extra entry is a zero reads a full bitmap.
      run_vals.delete();
      for (int v = MAX_LEN; v >= 1; v--) run_vals.insert(run_vals.size(), v);
      play_run();
      build_run(RUN_MONOTONE, MAX_LEN);
      play_run();
      build_run(RUN_OVERLONG, MAX_LEN);
      run_vals[MAX_LEN] = 0;
      play_run();
      overlong_runs++;

      while (words_sent < ITEM_TARGET) begin
         r = $urandom_range(99, 0);
         if (r < 55)      kind = RUN_PERM;
         else if (r < 62) kind = RUN_MONOTONE;
         else if (r < 72) kind = RUN_DUPLICATE;
         else if (r < 82) kind = RUN_OUT_OF_RANGE;
         else if (r < 88) kind = RUN_OVERLONG;
         else             kind = RUN_NOISE;
         len = (kind == RUN_OVERLONG) ? MAX_LEN : pick_len();
         if (kind == RUN_DUPLICATE && len < 2) len = 2;
         if (kind == RUN_OVERLONG) overlong_runs++;
         steady = ($urandom_range(4, 0) == 0);
         build_run(kind, len);
         play_run();
         if (runs_played % 20 == 0) drain();
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d expected result words never arrived", sb.pending()));
      end
      $display("Covered %0d runs and %0d words, %0d of them overlong runs.",
               runs_played, words_sent, overlong_runs);
      $display("Checked %0d result words; %0d runs confirmed as permutations.",
               sb.results_checked, sb.perms_confirmed);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Result side: random stalls before each word, with calm stretches.
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(9, 0);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_word(rsp_data);
      end
   end

   initial begin
      #400000;
      $display("Timed out with %0d result words outstanding.", sb.pending());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
